[rtl/kway_sorted_merge_defines.svh]
// Assertion macros for the k-way merge block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef KWAY_SORTED_MERGE_DEFINES_SVH
`define KWAY_SORTED_MERGE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define KWSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define KWSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/kwsm_pkg.sv]
// Package for the k-way merge block: operation codes, item types, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kwsm_pkg;

	localparam int STREAMS_DEF      = 8;
	localparam int STREAM_DEPTH_DEF = 256;

	localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [2:0]         stream;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic               empty_res;
		logic               full_res;
		logic               order_error;
	} res_t;

endpackage

`default_nettype wire

[rtl/kwsm_store.sv]
// Element store for all streams: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module kwsm_store #(
	parameter int STREAMS      = 8,
	parameter int STREAM_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(STREAMS)-1:0]      widx,
	input  logic [$clog2(STREAM_DEPTH)-1:0] wptr,
	input  logic signed [31:0]              wdata,
	input  logic                            re,
	input  logic [$clog2(STREAMS)-1:0]      ridx,
	input  logic [$clog2(STREAM_DEPTH)-1:0] rptr,
	output logic signed [31:0]              rdata
);

	logic signed [31:0] mem [STREAMS][STREAM_DEPTH];
	logic signed [31:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[widx][wptr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[ridx][rptr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/kwsm_cmp.sv]
// Shared signed less-than unit for head scanning and order checking.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kwsm_cmp (
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               lt
);

	// two's complement compare
	assign lt = (a < b);

endmodule

`default_nettype wire

[rtl/kwsm_seq.sv]
// Sequencer for the k-way merge: per-stream pointers, head scan, results.
// Depends on kwsm_pkg; drives kwsm_store and kwsm_cmp from the top level.
`timescale 1ns / 1ps
`default_nettype none

module kwsm_seq #(
	parameter int STREAMS      = 8,
	parameter int STREAM_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  kwsm_pkg::cmd_t                  cmd,
	output logic                            busy,
	output logic                            valid,
	output kwsm_pkg::res_t                  result,
	// store ports
	output logic                            we,
	output logic [$clog2(STREAMS)-1:0]      widx,
	output logic [$clog2(STREAM_DEPTH)-1:0] wptr,
	output logic signed [31:0]              wdata,
	output logic                            re,
	output logic [$clog2(STREAMS)-1:0]      ridx,
	output logic [$clog2(STREAM_DEPTH)-1:0] rptr,
	input  logic signed [31:0]              rdata,
	// comparator ports
	output logic signed [31:0]              cmp_a,
	output logic signed [31:0]              cmp_b,
	input  logic                            lt
);

	import kwsm_pkg::*;

	localparam int SW = $clog2(STREAMS);
	localparam int PW = $clog2(STREAM_DEPTH);
	localparam int FW = $clog2(STREAM_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [SW-1:0]      scan_q;
	logic               hit_s1;
	logic [SW-1:0]      idx_s1;
	logic               found_q;
	logic [SW-1:0]      best_q;
	logic signed [31:0] best_val_q;
	logic signed [31:0] last_q;
	logic [PW-1:0]      rd_q   [STREAMS];
	logic [PW-1:0]      wr_q   [STREAMS];
	logic [FW-1:0]      fill_q [STREAMS];
	res_t               res_q;
	logic               valid_q;

	logic [SW-1:0] ix;
	logic [PW-1:0] rd_ix;
	logic [PW-1:0] wr_ix;
	logic [FW-1:0] fill_ix;
	logic          push_ok;
	logic          upd;

	// pointer step with wrap at the stream depth
	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(STREAM_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// one stream index selects the per-stream counters in every state
	always_comb begin
		unique case (state_q)
			S_SCAN:  ix = scan_q;
			S_FIN:   ix = best_q;
			default: ix = SW'(cmd_q.stream);
		endcase
	end

	assign rd_ix   = rd_q[ix];
	assign wr_ix   = wr_q[ix];
	assign fill_ix = fill_q[ix];
	assign push_ok = (int'(cmd_q.stream) < STREAMS) && (fill_ix < FW'(STREAM_DEPTH));

	// store access
	assign we    = (state_q == S_EXEC) && (cmd_q.op == OP_PUSH) && push_ok;
	assign widx  = ix;
	assign wptr  = wr_ix;
	assign wdata = cmd_q.value;
	assign re    = (state_q == S_SCAN) && (fill_ix != '0);
	assign ridx  = ix;
	assign rptr  = rd_ix;

	// comparator: head against running minimum, or winner against last pop
	assign cmp_a = (state_q == S_FIN) ? best_val_q : rdata;
	assign cmp_b = (state_q == S_FIN) ? last_q : best_val_q;

	// head read last cycle takes the lead; ties keep the lower index
	assign upd = hit_s1 && (!found_q || lt);

	// sequencer, counters and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			hit_s1  <= 1'b0;
			found_q <= 1'b0;
			scan_q  <= '0;
			last_q  <= MOST_NEG;
			for (int i = 0; i < STREAMS; i++) begin
				rd_q[i]   <= '0;
				wr_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			valid_q <= 1'b0;
			hit_s1  <= 1'b0;
			if (upd) begin
				found_q    <= 1'b1;
				best_q     <= idx_s1;
				best_val_q <= rdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						scan_q  <= '0;
						found_q <= 1'b0;
						state_q <= (cmd.op == OP_POP) ? S_SCAN : S_EXEC;
					end
				end
				S_EXEC: begin
					res_q   <= '0;
					valid_q <= 1'b1;
					state_q <= S_IDLE;
					unique case (cmd_q.op)
						OP_PUSH: begin
							if (push_ok) begin
								wr_q[ix]   <= nxt(wr_ix);
								fill_q[ix] <= fill_ix + 1'b1;
							end else begin
								res_q.full_res <= 1'b1;
							end
						end
						OP_CLEAR: begin
							last_q <= MOST_NEG;
							for (int i = 0; i < STREAMS; i++) begin
								rd_q[i]   <= '0;
								wr_q[i]   <= '0;
								fill_q[i] <= '0;
							end
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					hit_s1 <= (fill_ix != '0);
					idx_s1 <= scan_q;
					if (scan_q == SW'(STREAMS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					res_q   <= '0;
					valid_q <= 1'b1;
					state_q <= S_IDLE;
					if (found_q) begin
						rd_q[ix]          <= nxt(rd_ix);
						fill_q[ix]        <= fill_ix - 1'b1;
						res_q.out_value   <= best_val_q;
						res_q.order_error <= lt;
						last_q            <= best_val_q;
					end else begin
						res_q.empty_res <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign result = res_q;

endmodule

`default_nettype wire

[rtl/kway_sorted_merge.sv]
// Top level of the k-way merge engine over sorted signed streams.
// Depends on kwsm_pkg, kwsm_store, kwsm_cmp, kwsm_seq and the defines header.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   command  | start, busy          | cmd    (kwsm_pkg::cmd_t)
//   result   | valid (1-cycle pulse)| result (kwsm_pkg::res_t)
//
// A push, clear or unused op passes through S_EXEC, which registers its result.
// A pop reads one stream head per cycle through the store's read port and the
// shared comparator in S_SCAN, then passes S_DRAIN; S_FIN registers the result.
// Reset clears pointers, fill counts and the last popped value at once; the
// store itself is not cleared. busy is high until the result is shown, and the
// next command may be taken in the cycle the result is on the ports.
`timescale 1ns / 1ps
`default_nettype none
`include "kway_sorted_merge_defines.svh"

module kway_sorted_merge #(
	parameter int STREAMS      = kwsm_pkg::STREAMS_DEF,
	parameter int STREAM_DEPTH = kwsm_pkg::STREAM_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  kwsm_pkg::cmd_t cmd,
	output logic           busy,
	output logic           valid,
	output kwsm_pkg::res_t result
);

	import kwsm_pkg::*;

	localparam int SW = $clog2(STREAMS);
	localparam int PW = $clog2(STREAM_DEPTH);

	logic               we;
	logic [SW-1:0]      widx;
	logic [PW-1:0]      wptr;
	logic signed [31:0] wdata;
	logic               re;
	logic [SW-1:0]      ridx;
	logic [PW-1:0]      rptr;
	logic signed [31:0] rdata;
	logic signed [31:0] cmp_a;
	logic signed [31:0] cmp_b;
	logic               lt;

	kwsm_store #(
		.STREAMS      (STREAMS),
		.STREAM_DEPTH (STREAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.widx  (widx),
		.wptr  (wptr),
		.wdata (wdata),
		.re    (re),
		.ridx  (ridx),
		.rptr  (rptr),
		.rdata (rdata)
	);

	kwsm_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (lt)
	);

	kwsm_seq #(
		.STREAMS      (STREAMS),
		.STREAM_DEPTH (STREAM_DEPTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.valid  (valid),
		.result (result),
		.we     (we),
		.widx   (widx),
		.wptr   (wptr),
		.wdata  (wdata),
		.re     (re),
		.ridx   (ridx),
		.rptr   (rptr),
		.rdata  (rdata),
		.cmp_a  (cmp_a),
		.cmp_b  (cmp_b),
		.lt     (lt)
	);

	// checks on the sequencer
	`KWSM_ASSERT_NEXT(a_busy_after_take, start && !busy, busy, "command taken but not busy")
	`KWSM_ASSERT_NOW(a_idle_on_result, valid, !busy, "result shown while still busy")
	`KWSM_ASSERT_NOW(a_one_flag, valid, $onehot0({result.empty_res, result.full_res, result.order_error}), "conflicting result flags")
	`KWSM_ASSERT_NOW(a_empty_zero, valid && result.empty_res, result.out_value == 32'sd0, "empty pop with nonzero value")

endmodule

`default_nettype wire

[tb/sv/kwsm_merge_checker.sv]
`timescale 1ns / 1ps
// Result checker for the k-way merge block: keeps its own copy of the streams,
// predicts the result of every accepted command and compares. Depends on kwsm_pkg.

module kwsm_merge_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  kwsm_pkg::cmd_t cmd,
	input  logic           valid,
	input  kwsm_pkg::res_t result,
	output int             fails,
	output int             pending,
	output int             checked
);

	import kwsm_pkg::*;

	localparam int NSTR  = STREAMS_DEF;
	localparam int DEPTH = STREAM_DEPTH_DEF;
	localparam int REPORT_MAX = 10;

	// shadow streams
	logic signed [31:0] stream_words [NSTR][DEPTH];
	int                 rd_ptr [NSTR];
	int                 wr_ptr [NSTR];
	int                 fill [NSTR];
	logic signed [31:0] last_out;

	res_t expected_q [$];
	int   n_fail;
	int   n_checked;

	function automatic void empty_streams();
		for (int i = 0; i < NSTR; i++) begin
			rd_ptr[i] = 0;
			wr_ptr[i] = 0;
			fill[i]   = 0;
		end
		last_out = MOST_NEG;
	endfunction

	// one command through the merge: update the shadow state, return the result
	function automatic res_t merge_step(cmd_t c);
		res_t               r;
		logic               found;
		int                 best;
		logic signed [31:0] best_val;
		int                 s;
		r        = '0;
		found    = 1'b0;
		best     = 0;
		best_val = '0;
		s        = int'(c.stream);
		case (c.op)
			OP_PUSH: begin
				if (s >= NSTR || fill[s] >= DEPTH) begin
					r.full_res = 1'b1;
				end else begin
					stream_words[s][wr_ptr[s]] = c.value;
					wr_ptr[s] = (wr_ptr[s] + 1 >= DEPTH) ? 0 : wr_ptr[s] + 1;
					fill[s]++;
				end
			end
			OP_POP: begin
				// smallest head wins, lowest index on a tie
				for (int i = 0; i < NSTR; i++) begin
					if (fill[i] != 0 && (!found || stream_words[i][rd_ptr[i]] < best_val)) begin
						found    = 1'b1;
						best     = i;
						best_val = stream_words[i][rd_ptr[i]];
					end
				end
				if (!found) begin
					r.empty_res = 1'b1;
				end else begin
					rd_ptr[best] = (rd_ptr[best] + 1 >= DEPTH) ? 0 : rd_ptr[best] + 1;
					fill[best]--;
					r.out_value   = best_val;
					r.order_error = (best_val < last_out);
					last_out      = best_val;
				end
			end
			OP_CLEAR: begin
				empty_streams();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic note_failure(string what);
		n_fail++;
		if (n_fail <= REPORT_MAX)
			$display("[%0t] %s", $time, what);
	endtask

	// watch both channels at every edge; results first, then the new command
	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			empty_streams();
			expected_q.delete();
			n_fail    = 0;
			n_checked = 0;
			fails   <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (valid) begin
				if (expected_q.size() == 0) begin
					note_failure($sformatf("result with nothing expected: value=%0d empty=%0b full=%0b order=%0b",
						result.out_value, result.empty_res, result.full_res,
						result.order_error));
				end else begin
					want = expected_q.pop_front();
					n_checked++;
					if (want.out_value !== result.out_value || want.empty_res !== result.empty_res
						|| want.full_res !== result.full_res
						|| want.order_error !== result.order_error) begin
						note_failure($sformatf({"mismatch: expected value=%0d empty=%0b full=%0b ",
							"order=%0b, got value=%0d empty=%0b full=%0b order=%0b"},
							want.out_value, want.empty_res, want.full_res, want.order_error,
							result.out_value, result.empty_res, result.full_res,
							result.order_error));
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(merge_step(cmd));
			fails   <= n_fail;
			pending <= expected_q.size();
			checked <= n_checked;
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the k-way merge testbench: clock, reset, command stimulus and verdict.
// Depends on kwsm_pkg, kway_sorted_merge and kwsm_merge_checker.

module testbench;
	import kwsm_pkg::*;

	localparam int NSTR        = STREAMS_DEF;
	localparam int DEPTH       = STREAM_DEPTH_DEF;
	localparam int ITEM_TARGET = 660;
	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_WAIT  = 30;
	localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic valid;
	res_t result;
	int   fails;
	int   pending;
	int   checked;

	// per-stream value cursor, keeps pushed sequences ascending
	longint cursor [NSTR];
	int     n_sent    = 0;
	int     n_push    = 0;
	int     n_pop     = 0;
	int     n_clear   = 0;
	int     n_noop    = 0;
	int     cycles    = 0;
	logic   idle_on   = 1'b1;
	int     mode_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	kway_sorted_merge DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.valid  (valid),
		.result (result)
	);

	kwsm_merge_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.valid   (valid),
		.result  (result),
		.fails   (fails),
		.pending (pending),
		.checked (checked)
	);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// issue one command item; random gap before it, stretches without gaps
	task automatic send(op_t code, int s, logic signed [31:0] v);
		int gap;
		if (mode_left <= 0) begin
			idle_on   = ($urandom_range(0, 3) != 0);
			mode_left = $urandom_range(10, 60);
		end
		mode_left--;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= '{op: code, stream: s[2:0], value: v};
		@(posedge clk);
		while (busy) @(posedge clk);
		n_sent++;
		case (code)
			OP_PUSH:  n_push++;
			OP_POP:   n_pop++;
			OP_CLEAR: n_clear++;
			default:  n_noop++;
		endcase
	endtask

	// start a stream's sequence somewhere in the signed range
	function automatic void reseed(int s);
		if ($urandom_range(0, 7) == 0)
			cursor[s] = longint'(MOST_NEG);
		else
			cursor[s] = longint'($signed($urandom()));
	endfunction

	// next ascending value for a stream, saturating at the top
	function automatic logic signed [31:0] next_in(int s);
		case ($urandom_range(0, 9))
			0:       ;  // repeat: ties within and across streams
			1:       cursor[s] += longint'($urandom());
			default: cursor[s] += $urandom_range(1, 5000);
		endcase
		if (cursor[s] > longint'(MOST_POS))
			cursor[s] = longint'(MOST_POS);
		return cursor[s][31:0];
	endfunction

	initial begin
		int fs;
		int fs_pushed;
		int phase_pushes;
		int o;
		int total;
		int npops;
		int left [NSTR];

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, extremes, ties, unsorted stream, unused op, clear
		send(OP_POP, 0, '0);
		send(OP_PUSH, 0, MOST_POS);
		send(OP_PUSH, 7, MOST_NEG);
		send(OP_PUSH, 3, 32'sd0);
		send(OP_PUSH, 3, -32'sd1);
		send(OP_PUSH, 1, 32'sd0);
		send(OP_NONE, 5, 32'sh5a5a_a5a5);
		// most negative, tie on zero, out-of-order -1, most positive, then empty
		repeat (6) send(OP_POP, 2, MOST_POS);
		send(OP_PUSH, 2, 32'sd5);
		send(OP_PUSH, 2, 32'sd6);
		send(OP_PUSH, 6, -32'sd7);
		send(OP_CLEAR, 7, -32'sd1);
		send(OP_POP, 0, '0);
		// after a clear a low value is no order error
		send(OP_PUSH, 4, -32'sd5);
		send(OP_POP, 4, '0);
		send(OP_PUSH, 5, 32'sha5a5_5a5a);
		send(OP_PUSH, 5, MOST_NEG);
		send(OP_POP, 5, '0);
		send(OP_POP, 5, '0);

		// fill one stream to the top, overflow it, then drain through pointer wrap
		send(OP_CLEAR, 0, '0);
		fs = $urandom_range(0, NSTR - 1);
		for (int i = 0; i < NSTR; i++)
			reseed(i);
		cursor[fs]   = longint'(MOST_NEG) + $urandom_range(0, 1000);
		fs_pushed    = 0;
		phase_pushes = 0;
		while (fs_pushed < DEPTH) begin
			if ($urandom_range(0, 7) == 0) begin
				o = (fs + $urandom_range(1, NSTR - 1)) % NSTR;
				send(OP_PUSH, o, next_in(o));
			end else begin
				send(OP_PUSH, fs, next_in(fs));
				fs_pushed++;
			end
			phase_pushes++;
		end
		repeat (2) send(OP_PUSH, fs, next_in(fs));
		repeat (phase_pushes + 1) send(OP_POP, $urandom_range(0, NSTR - 1), $urandom());

		// random merge rounds: mostly sorted fills then pops, some noise and cut-short rounds
		while (n_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(4, 12))
					send(op_t'($urandom_range(0, 3)), $urandom_range(0, NSTR - 1), $urandom());
			end else begin
				if ($urandom_range(0, 4) != 0)
					send(OP_CLEAR, $urandom_range(0, NSTR - 1), $urandom());
				total = 0;
				for (int i = 0; i < NSTR; i++) begin
					left[i] = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 10) : 0;
					total  += left[i];
					reseed(i);
				end
				npops = total;
				while (total > 0) begin
					do o = $urandom_range(0, NSTR - 1); while (left[o] == 0);
					send(OP_PUSH, o, next_in(o));
					left[o]--;
					total--;
				end
				// a cut-short round leaves values behind for the next one
				if ($urandom_range(0, 5) == 0)
					npops = $urandom_range(0, npops);
				else
					npops = npops + $urandom_range(0, 2);
				repeat (npops) begin
					if ($urandom_range(0, 9) == 0) begin
						o = $urandom_range(0, NSTR - 1);
						send(OP_PUSH, o, next_in(o));
					end
					send(OP_POP, $urandom_range(0, NSTR - 1), $urandom());
				end
			end
		end

		// wait out the last results
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d commands: %0d push, %0d pop, %0d clear, %0d unused op",
			n_sent, n_push, n_pop, n_clear, n_noop);
		$display("%0d results compared, %0d failures", checked, fails);
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[kway_sorted_merge.f]
+incdir+rtl
rtl/kwsm_pkg.sv
rtl/kwsm_store.sv
rtl/kwsm_cmp.sv
rtl/kwsm_seq.sv
rtl/kway_sorted_merge.sv
tb/sv/kwsm_merge_checker.sv
tb/sv/testbench.sv
